FILE: sv/qsa_pkg.sv
`default_nettype none
package qsa_pkg;

    // Joint table depth and the address bits that follow from it.
    localparam int MAX_JOINTS = 64;
    localparam int JADDR_W    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    // Wide enough to hold any joint index and the largest table depth.
    localparam int JEXT_W     = 9;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // One joint table entry: position Q16.16, orientation and inverse Q1.14.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [15:0] ix;
        logic signed [15:0] iy;
        logic signed [15:0] iz;
        logic signed [15:0] iw;
    } t_joint;

    localparam int JOINT_W = $bits(t_joint);

endpackage
`default_nettype wire

FILE: sv/qsa_if.sv
`default_nettype none
// Input word channel: joint loads and weight contributions.
interface qsa_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [5:0]         joint_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [15:0]        bias;
    logic               last_weight;

    modport source (
        output valid, cmd, joint_index, pos_x, pos_y, pos_z,
               quat_x, quat_y, quat_z, quat_w, bias, last_weight,
        input  ready
    );
    modport sink (
        input  valid, cmd, joint_index, pos_x, pos_y, pos_z,
               quat_x, quat_y, quat_z, quat_w, bias, last_weight,
        output ready
    );
endinterface

// Output word channel: skinned vertices.
interface qsa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               saturated;

    modport source (
        output valid, vert_x, vert_y, vert_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, vert_x, vert_y, vert_z, saturated,
        output ready
    );
endinterface
`default_nettype wire

FILE: sv/quaternion_skinning_accumulator.sv
// Weight word: no new word is taken until the sequence is back in IDLE; the
// vertex is registered into the output register from ACC after its last weight.
// Load word: a 17-step square root and a 31-step divider, skipped for a zero root.
// Throughput is set by one shared multiplier that forms one product per cycle.
// Reset (synchronous, active low) clears the control, the output valid and the
// accumulators; joint table contents are undefined until loaded.
`default_nettype none
module quaternion_skinning_accumulator (
    input wire logic i_clk,
    input wire logic i_rst_n,
    qsa_in_if.sink   i_item,
    qsa_out_if.source o_vert
);
    import qsa_pkg::*;

    // Sequencer states. A weight runs MAC then ACC. A load runs MAC (squares),
    // SQRT, PREP, DIV (skipped for a zero root) and WRITE.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAC   = 7'b0000010,
        S_ACC   = 7'b0000100,
        S_SQRT  = 7'b0001000,
        S_PREP  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_WRITE = 7'b1000000
    } t_state;

    // Where a finished multiply-accumulate sum is stored.
    typedef enum logic [3:0] {
        D_NONE, D_TW, D_TX, D_TY, D_TZ, D_FX, D_FY, D_FZ,
        D_CX, D_CY, D_CZ, D_S
    } t_dest;

    localparam logic [4:0] MAC_END_WEIGHT = 5'd29;
    localparam logic [4:0] MAC_END_LOAD   = 5'd4;
    localparam logic [4:0] SQRT_END       = 5'd16;
    localparam logic [4:0] DIV_END        = 5'd30;

    t_state r_state;
    logic [4:0] r_cnt;

    // Latched input word.
    logic               r_cmd;
    logic [JADDR_W-1:0] r_jaddr;
    logic               r_jvalid;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [15:0] r_q [4];
    logic [15:0]        r_bias;
    logic               r_last;

    logic [JEXT_W-1:0]  w_jext;
    logic               w_accept;

    // Joint table memory.
    t_joint             w_rd;
    t_joint             w_wd;
    logic [JOINT_W-1:0] w_rdata;
    logic               w_we;

    // Multiplier stage.
    logic               w_act, w_neg, w_first;
    t_dest              w_dest;
    logic signed [40:0] w_a;
    logic signed [16:0] w_b;
    logic               r_p_act, r_p_neg, r_p_first;
    t_dest              r_p_dest;
    logic signed [57:0] r_prod;

    // Accumulate stage.
    logic signed [63:0] r_macc;
    logic signed [63:0] w_term, w_sum, w_r14, w_r15;
    logic signed [39:0] r_tw, r_tx, r_ty, r_tz, r_fx, r_fy, r_fz;
    logic signed [47:0] r_c [3];

    // Square root and divider.
    logic [33:0]        r_sq_s, r_sq_r, r_sq_bit, w_sq_trial;
    logic [16:0]        w_root;
    logic [15:0]        w_mag [4];
    logic               w_cneg [4];
    logic [30:0]        r_dq [4];
    logic [16:0]        r_rem [4];
    logic [17:0]        w_rt [4];
    logic               w_ge [4];

    // Vertex accumulator.
    logic signed [47:0] r_acc [3];
    logic               r_aclip;
    logic signed [48:0] w_asum [3];
    logic signed [47:0] w_asat [3];
    logic               w_aovf [3];
    logic [31:0]        w_clip [3];
    logic               w_cflag [3];
    logic               w_proceed;

    // Output register.
    logic               r_ovalid;
    logic signed [31:0] r_vx, r_vy, r_vz;
    logic               r_vsat;

    function automatic logic [31:0] clip32(input logic signed [47:0] v);
        logic fits;
        fits = (&v[47:31]) | ~(|v[47:31]);
        if (fits) begin
            return v[31:0];
        end
        return v[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_jext       = JEXT_W'(i_item.joint_index);

    assign w_rd = t_joint'(w_rdata);
    assign w_we = (r_state == S_WRITE) && r_jvalid;

    qsa_ram #(
        .WIDTH(JOINT_W),
        .DEPTH(MAX_JOINTS)
    ) u_joint_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_jaddr),
        .i_wdata(w_wd),
        .i_re   (w_accept && i_item.cmd == CMD_WEIGHT),
        .i_raddr(w_jext[JADDR_W-1:0]),
        .o_rdata(w_rdata)
    );

    // Conjugate magnitudes and signs for the inverse.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mag[k] = r_q[k][15] ? 16'(-r_q[k]) : 16'(r_q[k]);
            if (k < 3) begin
                w_cneg[k] = !r_q[k][15] && (r_q[k] != 16'sd0);
            end else begin
                w_cneg[k] = r_q[k][15];
            end
        end
    end

    always_comb begin
        w_wd       = '0;
        w_wd.pos_x = r_px;
        w_wd.pos_y = r_py;
        w_wd.pos_z = r_pz;
        w_wd.qx    = r_q[0];
        w_wd.qy    = r_q[1];
        w_wd.qz    = r_q[2];
        w_wd.qw    = r_q[3];
        w_wd.ix    = w_cneg[0] ? -$signed(r_dq[0][15:0]) : $signed(r_dq[0][15:0]);
        w_wd.iy    = w_cneg[1] ? -$signed(r_dq[1][15:0]) : $signed(r_dq[1][15:0]);
        w_wd.iz    = w_cneg[2] ? -$signed(r_dq[2][15:0]) : $signed(r_dq[2][15:0]);
        w_wd.iw    = w_cneg[3] ? -$signed(r_dq[3][15:0]) : $signed(r_dq[3][15:0]);
    end

    // Step table for the shared multiplier. A weight forms t = q*v over twelve
    // products, then f = t*inv(q) over twelve more, then the three bias products.
    // A free step after each group lets the last sum land before it is used.
    always_comb begin
        w_act   = 1'b0;
        w_neg   = 1'b0;
        w_first = 1'b0;
        w_dest  = D_NONE;
        w_a     = '0;
        w_b     = '0;
        if (r_state == S_MAC) begin
            if (r_cmd == CMD_LOAD) begin
                w_act = (r_cnt < MAC_END_LOAD);
                if (r_cnt < MAC_END_LOAD) begin
                    w_a = 41'(r_q[r_cnt[1:0]]);
                    w_b = 17'(r_q[r_cnt[1:0]]);
                end
                w_first = (r_cnt == 5'd0);
                w_dest  = (r_cnt == 5'd3) ? D_S : D_NONE;
            end else begin
                w_act = 1'b1;
                case (r_cnt)
                    5'd0:  begin w_a = 41'(r_px); w_b = 17'(w_rd.qx);
                                 w_neg = 1'b1; w_first = 1'b1; end
                    5'd1:  begin w_a = 41'(r_py); w_b = 17'(w_rd.qy); w_neg = 1'b1; end
                    5'd2:  begin w_a = 41'(r_pz); w_b = 17'(w_rd.qz);
                                 w_neg = 1'b1; w_dest = D_TW; end
                    5'd3:  begin w_a = 41'(r_px); w_b = 17'(w_rd.qw); w_first = 1'b1; end
                    5'd4:  begin w_a = 41'(r_pz); w_b = 17'(w_rd.qy); end
                    5'd5:  begin w_a = 41'(r_py); w_b = 17'(w_rd.qz);
                                 w_neg = 1'b1; w_dest = D_TX; end
                    5'd6:  begin w_a = 41'(r_py); w_b = 17'(w_rd.qw); w_first = 1'b1; end
                    5'd7:  begin w_a = 41'(r_px); w_b = 17'(w_rd.qz); end
                    5'd8:  begin w_a = 41'(r_pz); w_b = 17'(w_rd.qx);
                                 w_neg = 1'b1; w_dest = D_TY; end
                    5'd9:  begin w_a = 41'(r_pz); w_b = 17'(w_rd.qw); w_first = 1'b1; end
                    5'd10: begin w_a = 41'(r_py); w_b = 17'(w_rd.qx); end
                    5'd11: begin w_a = 41'(r_px); w_b = 17'(w_rd.qy);
                                 w_neg = 1'b1; w_dest = D_TZ; end
                    5'd13: begin w_a = 41'(r_tx); w_b = 17'(w_rd.iw); w_first = 1'b1; end
                    5'd14: begin w_a = 41'(r_tw); w_b = 17'(w_rd.ix); end
                    5'd15: begin w_a = 41'(r_ty); w_b = 17'(w_rd.iz); end
                    5'd16: begin w_a = 41'(r_tz); w_b = 17'(w_rd.iy);
                                 w_neg = 1'b1; w_dest = D_FX; end
                    5'd17: begin w_a = 41'(r_ty); w_b = 17'(w_rd.iw); w_first = 1'b1; end
                    5'd18: begin w_a = 41'(r_tw); w_b = 17'(w_rd.iy); end
                    5'd19: begin w_a = 41'(r_tz); w_b = 17'(w_rd.ix); end
                    5'd20: begin w_a = 41'(r_tx); w_b = 17'(w_rd.iz);
                                 w_neg = 1'b1; w_dest = D_FY; end
                    5'd21: begin w_a = 41'(r_tz); w_b = 17'(w_rd.iw); w_first = 1'b1; end
                    5'd22: begin w_a = 41'(r_tw); w_b = 17'(w_rd.iz); end
                    5'd23: begin w_a = 41'(r_tx); w_b = 17'(w_rd.iy); end
                    5'd24: begin w_a = 41'(r_ty); w_b = 17'(w_rd.ix);
                                 w_neg = 1'b1; w_dest = D_FZ; end
                    5'd26: begin w_a = 41'(w_rd.pos_x) + 41'(r_fx);
                                 w_b = $signed({1'b0, r_bias});
                                 w_first = 1'b1; w_dest = D_CX; end
                    5'd27: begin w_a = 41'(w_rd.pos_y) + 41'(r_fy);
                                 w_b = $signed({1'b0, r_bias});
                                 w_first = 1'b1; w_dest = D_CY; end
                    5'd28: begin w_a = 41'(w_rd.pos_z) + 41'(r_fz);
                                 w_b = $signed({1'b0, r_bias});
                                 w_first = 1'b1; w_dest = D_CZ; end
                    default: w_act = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_act <= 1'b0;
        end else begin
            r_p_act <= w_act;
        end
        r_prod    <= w_a * w_b;
        r_p_neg   <= w_neg;
        r_p_first <= w_first;
        r_p_dest  <= w_dest;
    end

    // Accumulate stage with round-half-up at the end of each sum.
    assign w_term = r_p_neg ? -64'(r_prod) : 64'(r_prod);
    assign w_sum  = (r_p_first ? 64'sd0 : r_macc) + w_term;
    assign w_r14  = (w_sum + 64'sd8192) >>> 14;
    assign w_r15  = (w_sum + 64'sd16384) >>> 15;

    always_ff @(posedge i_clk) begin
        if (r_p_act) begin
            r_macc <= w_sum;
            case (r_p_dest)
                D_TW:    r_tw   <= 40'(w_r14);
                D_TX:    r_tx   <= 40'(w_r14);
                D_TY:    r_ty   <= 40'(w_r14);
                D_TZ:    r_tz   <= 40'(w_r14);
                D_FX:    r_fx   <= 40'(w_r14);
                D_FY:    r_fy   <= 40'(w_r14);
                D_FZ:    r_fz   <= 40'(w_r14);
                D_CX:    r_c[0] <= 48'(w_r15);
                D_CY:    r_c[1] <= 48'(w_r15);
                D_CZ:    r_c[2] <= 48'(w_r15);
                default: ;
            endcase
        end
    end

    // Digit-by-digit square root of the squared magnitude, one digit a cycle.
    assign w_sq_trial = r_sq_r + r_sq_bit;
    assign w_root     = r_sq_r[16:0];

    always_ff @(posedge i_clk) begin
        if (r_p_act && r_p_dest == D_S) begin
            r_sq_s   <= 34'(w_sum);
            r_sq_r   <= '0;
            r_sq_bit <= 34'h1_0000_0000;
        end else if (r_state == S_SQRT) begin
            if (r_sq_s >= w_sq_trial) begin
                r_sq_s <= r_sq_s - w_sq_trial;
                r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
            end else begin
                r_sq_r <= r_sq_r >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    // Four restoring divider lanes, one quotient bit a cycle.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_rt[k] = {r_rem[k], r_dq[k][30]};
            w_ge[k] = (w_rt[k] >= {1'b0, w_root});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (r_state == S_PREP) begin
                r_rem[k] <= '0;
                if (w_root == 17'd0) begin
                    r_dq[k] <= 31'(w_mag[k]);
                end else begin
                    r_dq[k] <= (31'(w_mag[k]) << 14) + 31'(w_root >> 1);
                end
            end else if (r_state == S_DIV) begin
                r_rem[k] <= w_ge[k] ? 17'(w_rt[k] - {1'b0, w_root}) : w_rt[k][16:0];
                r_dq[k]  <= {r_dq[k][29:0], w_ge[k]};
            end
        end
    end

    // Vertex accumulation, saturating to 48 bits, and the 32-bit clip on emit.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_asum[k]  = 49'(r_acc[k]) + (r_jvalid ? 49'(r_c[k]) : 49'sd0);
            w_aovf[k]  = w_asum[k][48] ^ w_asum[k][47];
            if (w_aovf[k]) begin
                w_asat[k] = w_asum[k][48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end else begin
                w_asat[k] = w_asum[k][47:0];
            end
            w_clip[k]  = clip32(w_asat[k]);
            w_cflag[k] = !((&w_asat[k][47:31]) | ~(|w_asat[k][47:31]));
        end
    end

    // A vertex waits in ACC only while the previous vertex is still unread.
    assign w_proceed = !(r_last && r_ovalid && !o_vert.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= '0;
            end
            r_aclip <= 1'b0;
        end else if (r_state == S_ACC && w_proceed) begin
            if (r_last) begin
                for (int k = 0; k < 3; k++) begin
                    r_acc[k] <= '0;
                end
                r_aclip <= 1'b0;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_acc[k] <= w_asat[k];
                end
                r_aclip <= r_aclip | w_aovf[0] | w_aovf[1] | w_aovf[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_ACC && r_last && w_proceed) begin
            r_ovalid <= 1'b1;
        end else if (o_vert.ready) begin
            r_ovalid <= 1'b0;
        end
        if (r_state == S_ACC && r_last && w_proceed) begin
            r_vx   <= w_clip[0];
            r_vy   <= w_clip[1];
            r_vz   <= w_clip[2];
            r_vsat <= r_aclip | w_aovf[0] | w_aovf[1] | w_aovf[2]
                      | w_cflag[0] | w_cflag[1] | w_cflag[2];
        end
    end

    assign o_vert.valid     = r_ovalid;
    assign o_vert.vert_x    = r_vx;
    assign o_vert.vert_y    = r_vy;
    assign o_vert.vert_z    = r_vz;
    assign o_vert.saturated = r_vsat;

    // Input word latch.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_item.cmd;
            r_jaddr  <= w_jext[JADDR_W-1:0];
            r_jvalid <= (w_jext < JEXT_W'(MAX_JOINTS));
            r_px     <= i_item.pos_x;
            r_py     <= i_item.pos_y;
            r_pz     <= i_item.pos_z;
            r_q[0]   <= i_item.quat_x;
            r_q[1]   <= i_item.quat_y;
            r_q[2]   <= i_item.quat_z;
            r_q[3]   <= i_item.quat_w;
            r_bias   <= i_item.bias;
            r_last   <= i_item.last_weight;
        end
    end

    // Sequencer. Only one word is in flight, so a table write always completes
    // before the next read of the same entry is issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept) begin
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_cmd == CMD_LOAD && r_cnt == MAC_END_LOAD) begin
                        r_state <= S_SQRT;
                        r_cnt   <= '0;
                    end else if (r_cmd == CMD_WEIGHT && r_cnt == MAC_END_WEIGHT) begin
                        r_state <= S_ACC;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_ACC: begin
                    if (w_proceed) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == SQRT_END) begin
                        r_state <= S_PREP;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_PREP: begin
                    r_cnt   <= '0;
                    r_state <= (w_root == 17'd0) ? S_WRITE : S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == DIV_END) begin
                        r_state <= S_WRITE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_cnt   <= '0;
                end
            endcase
        end
    end

    // An accepted word always starts a sequence.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start a sequence");

    // Emitting a vertex leaves the accumulator cleared.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_last && w_proceed) |=>
        (r_acc[0] == 48'sd0 && r_acc[1] == 48'sd0 && r_acc[2] == 48'sd0 && !r_aclip))
        else $error("accumulator not cleared after vertex emit");

    // A new vertex appears only from the accumulate step.
    a_out_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_ACC))
        else $error("output valid raised outside accumulate step");

endmodule
`default_nettype wire

FILE: sv/qsa_ram.sv
`default_nettype none
// Simple dual-port RAM, one write port and one registered read port.
module qsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: bench/qsa_skin_checker.sv
`default_nettype none
module qsa_skin_checker
    import qsa_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    qsa_in_if.sink   i_item_mon,
    qsa_out_if.sink  i_vert_mon,
    output int       o_fail_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_vertex;

    localparam logic signed [63:0] ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_LO = -ACC_HI - 64'sd1;

    logic signed [31:0] jpos [MAX_JOINTS][3];
    logic signed [63:0] jrot [MAX_JOINTS][4];
    logic signed [63:0] jinv [MAX_JOINTS][4];
    logic signed [63:0] acc [3];
    logic               acc_clipped;
    t_vertex            vertex_queue [$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = vertex_queue.size();

    // Round half up: floor((x + 2^(n-1)) / 2^n).
    function automatic logic signed [63:0] round_shift(logic signed [63:0] x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] acc_sum(logic signed [63:0] a,
                                                   logic signed [63:0] d);
        logic signed [63:0] s;
        s = a + d;
        if (s > ACC_HI) begin
            acc_clipped = 1'b1;
            return ACC_HI;
        end
        if (s < ACC_LO) begin
            acc_clipped = 1'b1;
            return ACC_LO;
        end
        return s;
    endfunction

    function automatic logic signed [31:0] clip_word(logic signed [63:0] v, ref logic f);
        if (v > 64'sh7FFF_FFFF) begin
            f = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            f = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    task automatic store_joint(int j);
        logic signed [63:0] q [4];
        logic signed [63:0] c [4];
        logic [63:0]        s;
        logic [63:0]        r;
        logic [63:0]        m;
        s = 0;
        jpos[j][0] = i_item_mon.pos_x;
        jpos[j][1] = i_item_mon.pos_y;
        jpos[j][2] = i_item_mon.pos_z;
        q[0] = i_item_mon.quat_x;
        q[1] = i_item_mon.quat_y;
        q[2] = i_item_mon.quat_z;
        q[3] = i_item_mon.quat_w;
        for (int k = 0; k < 4; k++) begin
            jrot[j][k] = q[k];
            s = s + q[k] * q[k];
        end
        c[0] = -q[0]; c[1] = -q[1]; c[2] = -q[2]; c[3] = q[3];
        r = int_sqrt(s);
        for (int k = 0; k < 4; k++) begin
            if (r == 0) begin
                jinv[j][k] = c[k];
            end else begin
                m = (c[k] < 0) ? -c[k] : c[k];
                m = (m * 16384 + r / 2) / r;
                jinv[j][k] = (c[k] < 0) ? -$signed(m) : $signed(m);
            end
        end
    endtask

    task automatic blend_weight(int j);
        logic signed [63:0] v [3];
        logic signed [63:0] t [4];
        logic signed [63:0] f [3];
        logic signed [63:0] b;
        logic signed [63:0] qx, qy, qz, qw, ix, iy, iz, iw;
        v[0] = i_item_mon.pos_x;
        v[1] = i_item_mon.pos_y;
        v[2] = i_item_mon.pos_z;
        b = {48'd0, i_item_mon.bias};
        qx = jrot[j][0]; qy = jrot[j][1]; qz = jrot[j][2]; qw = jrot[j][3];
        ix = jinv[j][0]; iy = jinv[j][1]; iz = jinv[j][2]; iw = jinv[j][3];
        // t = q * v, then f = t * inverse(q); t[3] is the scalar part.
        t[3] = round_shift(-(qx * v[0]) - (qy * v[1]) - (qz * v[2]), 14);
        t[0] = round_shift((qw * v[0]) + (qy * v[2]) - (qz * v[1]), 14);
        t[1] = round_shift((qw * v[1]) + (qz * v[0]) - (qx * v[2]), 14);
        t[2] = round_shift((qw * v[2]) + (qx * v[1]) - (qy * v[0]), 14);
        f[0] = round_shift((t[0] * iw) + (t[3] * ix) + (t[1] * iz) - (t[2] * iy), 14);
        f[1] = round_shift((t[1] * iw) + (t[3] * iy) + (t[2] * ix) - (t[0] * iz), 14);
        f[2] = round_shift((t[2] * iw) + (t[3] * iz) + (t[0] * iy) - (t[1] * ix), 14);
        for (int k = 0; k < 3; k++)
            acc[k] = acc_sum(acc[k], round_shift((64'(jpos[j][k]) + f[k]) * b, 15));
    endtask

    always @(posedge i_clk) begin
        t_vertex e;
        logic    f;
        if (!i_rst_n) begin
            acc = '{0, 0, 0};
            acc_clipped = 1'b0;
            vertex_queue.delete();
            fails = 0;
        end else begin
            if (i_item_mon.valid && i_item_mon.ready) begin
                if (i_item_mon.cmd == CMD_LOAD) begin
                    if (int'(i_item_mon.joint_index) < MAX_JOINTS)
                        store_joint(int'(i_item_mon.joint_index));
                end else begin
                    if (int'(i_item_mon.joint_index) < MAX_JOINTS)
                        blend_weight(int'(i_item_mon.joint_index));
                    if (i_item_mon.last_weight) begin
                        f = acc_clipped;
                        e.x = clip_word(acc[0], f);
                        e.y = clip_word(acc[1], f);
                        e.z = clip_word(acc[2], f);
                        e.sat = f;
                        vertex_queue.push_back(e);
                        acc = '{0, 0, 0};
                        acc_clipped = 1'b0;
                    end
                end
            end
            if (i_vert_mon.valid && i_vert_mon.ready) begin
                if (vertex_queue.size() == 0) begin
                    $error("vertex word with no expectation waiting");
                    fails++;
                end else begin
                    e = vertex_queue.pop_front();
                    if (i_vert_mon.vert_x !== e.x) begin
                        $error("vert_x expected %0d actual %0d", e.x, i_vert_mon.vert_x);
                        fails++;
                    end
                    if (i_vert_mon.vert_y !== e.y) begin
                        $error("vert_y expected %0d actual %0d", e.y, i_vert_mon.vert_y);
                        fails++;
                    end
                    if (i_vert_mon.vert_z !== e.z) begin
                        $error("vert_z expected %0d actual %0d", e.z, i_vert_mon.vert_z);
                        fails++;
                    end
                    if (i_vert_mon.saturated !== e.sat) begin
                        $error("saturated expected %0b actual %0b", e.sat,
                               i_vert_mon.saturated);
                        fails++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: bench/tb.sv
`default_nettype none
module tb;
    import qsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Slowest case: a load word with its square root and divider, plus sender gaps
    // and receiver stalls; 1600 words stay far below this limit.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_WORDS = 1600;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;
    // The long no-idling stretch and the receiver hold-off are steered from here.
    bit   calm = 1'b0;
    bit   hold_off = 1'b0;
    // Tracks which joints have been loaded so weights never touch empty entries.
    bit   loaded [MAX_JOINTS];

    qsa_in_if  item_ch ();
    qsa_out_if vert_ch ();

    quaternion_skinning_accumulator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_vert  (vert_ch.source)
    );

    qsa_skin_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_mon   (item_ch.sink),
        .i_vert_mon   (vert_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // The watchdog ends a hung run with the failure verdict.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver stalls at random, except in the calm stretch; during the
    // hold-off it keeps ready low so the block fills up and stalls its input.
    initial vert_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            vert_ch.ready <= 1'b0;
        else
            vert_ch.ready <= calm || ($urandom_range(99) >= 35);
    end

    initial begin
        item_ch.valid       = 1'b0;
        item_ch.cmd         = CMD_LOAD;
        item_ch.joint_index = '0;
        item_ch.pos_x       = '0;
        item_ch.pos_y       = '0;
        item_ch.pos_z       = '0;
        item_ch.quat_x      = '0;
        item_ch.quat_y      = '0;
        item_ch.quat_z      = '0;
        item_ch.quat_w      = '0;
        item_ch.bias        = '0;
        item_ch.last_weight = 1'b0;
    end

    // Offers one word, idling first at random, and returns once it is taken.
    // Valid stays high from one word to the next when there is no gap.
    task automatic send_word(logic c, logic [5:0] j, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] pz,
                             logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz, logic signed [15:0] qw,
                             logic [15:0] b, logic lw);
        while (!calm && $urandom_range(99) < 35) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= c;
        item_ch.joint_index <= j;
        item_ch.pos_x       <= px;
        item_ch.pos_y       <= py;
        item_ch.pos_z       <= pz;
        item_ch.quat_x      <= qx;
        item_ch.quat_y      <= qy;
        item_ch.quat_z      <= qz;
        item_ch.quat_w      <= qw;
        item_ch.bias        <= b;
        item_ch.last_weight <= lw;
        do @(posedge i_clk); while (!item_ch.ready);
        if (c == CMD_LOAD && int'(j) < MAX_JOINTS)
            loaded[j] = 1'b1;
    endtask

    function automatic logic signed [15:0] rand_quat();
        return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endfunction

    // Mostly moderate coordinates, sometimes the full 32-bit range.
    function automatic logic signed [31:0] rand_pos();
        if ($urandom_range(9) < 7)
            return $signed(32'($urandom_range(2 ** 24))) - 32'sd8388608;
        return $urandom;
    endfunction

    task automatic rand_load(int j);
        send_word(CMD_LOAD, 6'(j), rand_pos(), rand_pos(), rand_pos(), rand_quat(),
                  rand_quat(), rand_quat(), rand_quat(), 16'($urandom_range(65535)),
                  1'($urandom));
    endtask

    // Picks a joint that has been loaded.
    function automatic int pick_joint();
        int j;
        do j = $urandom_range(MAX_JOINTS - 1); while (!loaded[j]);
        return j;
    endfunction

    initial begin
        int n;
        int k;
        bit pressed;
        pressed = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Identity, zero and extreme quaternions.
        send_word(CMD_LOAD, 6'd0, 32'sd65536, -32'sd65536, 32'sd0,
                  16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd0, 1'b0);
        // A load that carries the last mark emits nothing.
        send_word(CMD_LOAD, 6'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 16'hFFFF, 1'b1);
        // Zero quaternion keeps the unscaled, all-zero conjugate.
        send_word(CMD_LOAD, 6'd2, 32'sd12345, 32'sd0, -32'sd99999,
                  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
        send_word(CMD_LOAD, 6'd63, -32'sd1, 32'sd1, 32'sh8000_0000,
                  -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
        send_word(CMD_LOAD, 6'd3, 32'sd0, 32'sd0, 32'sd0,
                  16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'd0, 1'b0);
        // Weights: zero and full bias, single-weight vertices.
        send_word(CMD_WEIGHT, 6'd0, 32'sd65536, 32'sd0, 32'sd0,
                  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd32768, 1'b1);
        send_word(CMD_WEIGHT, 6'd2, 32'sd7, 32'sd8, 32'sd9,
                  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1);
        send_word(CMD_WEIGHT, 6'd3, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1,
                  -16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'd16384, 1'b1);
        // Coordinate saturation: full-scale joints summed several times.
        for (k = 0; k < 4; k++)
            send_word(CMD_WEIGHT, 6'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd32768, 1'(k == 3));
        send_word(CMD_WEIGHT, 6'd63, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b0);
        send_word(CMD_WEIGHT, 6'd63, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b1);

        // Random part. Loads first fill the whole table with random content.
        for (k = 0; k < MAX_JOINTS; k++)
            rand_load(k);
        n = 0;
        while (n < RANDOM_WORDS) begin
            // A calm stretch with neither side idling in the second quarter.
            calm = (n >= RANDOM_WORDS / 4 && n < RANDOM_WORDS / 4 + 200);
            if (!pressed && n >= RANDOM_WORDS / 2) begin
                // Hold the receiver off while vertices keep coming.
                pressed = 1'b1;
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (1500) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if ($urandom_range(9) == 0) begin
                rand_load($urandom_range(MAX_JOINTS - 1));
                n++;
            end else begin
                // A vertex of one to four weights with random content.
                k = $urandom_range(1, 4);
                for (int w = 0; w < k; w++) begin
                    send_word(CMD_WEIGHT, 6'(pick_joint()), rand_pos(), rand_pos(),
                              rand_pos(), rand_quat(), rand_quat(), rand_quat(),
                              rand_quat(), ($urandom_range(3) == 0) ?
                              16'($urandom) : 16'($urandom_range(32768 / k)),
                              1'(w == k - 1));
                    n++;
                end
            end
        end
        item_ch.valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
